// ===== rtl/paprot_pkg.sv =====
// Shared types, angle constants and elaboration-time table functions for the
// polar array point rotator. No dependencies; every rtl module uses this package.
`default_nettype none

package paprot_pkg;

  // Datapath widths inside the rotator: coordinates in Q36, angles in radians Q48.
  localparam int XW = 56;
  localparam int ZW = 50;

  // Angles in degrees with 16 fraction bits.
  localparam logic [24:0] DEG45  = 25'd2949120;
  localparam logic [24:0] DEG90  = 25'd5898240;
  localparam logic [24:0] DEG135 = 25'd8847360;
  localparam logic [24:0] DEG180 = 25'd11796480;
  localparam logic [24:0] DEG225 = 25'd14745600;
  localparam logic [24:0] DEG270 = 25'd17694720;
  localparam logic [24:0] DEG315 = 25'd20643840;
  localparam logic [24:0] DEG360 = 25'd23592960;

  // Pi in Q60 and the degree-to-radian factor pi/180 in Q40.
  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
  localparam logic [34:0] RAD_C  = 35'((PI_Q60 >> 20) / 64'd180);

  // Saturation limits of a signed 32-bit coordinate.
  localparam logic [31:0] S32_MAX = 32'h7FFFFFFF;
  localparam logic [31:0] S32_MIN = 32'h80000000;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_CENTER_X     = 3'd0,
    CFG_CENTER_Y     = 3'd1,
    CFG_DELTA_ANGLE  = 3'd2,
    CFG_OFFSET_ANGLE = 3'd3,
    CFG_OFFSET_MODE  = 3'd4
  } cfg_index_t;

  // Start angle selection.
  typedef enum logic [1:0] {
    MODE_NONE  = 2'd0,
    MODE_DELTA = 2'd1,
    MODE_FREE  = 2'd2
  } offset_mode_t;

  // Whole quarter turns applied after the rotator.
  typedef enum logic [1:0] {
    QUAD_0   = 2'd0,
    QUAD_90  = 2'd1,
    QUAD_180 = 2'd2,
    QUAD_270 = 2'd3
  } quad_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [15:0]        instance_req;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic               saturated;
  } out_item_t;

  // Vector handed from one rotator cell to the next.
  typedef struct packed {
    logic                 valid;
    quad_t                quad;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_vec_t;

  // Restoring division, used only on constants at elaboration.
  function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Integer square root, used only on constants at elaboration.
  function automatic logic [63:0] isqrt_u64(input logic [63:0] val);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] bt;
    v  = val;
    r  = '0;
    bt = 64'd1 << 62;
    for (int s = 0; s < 32; s++) begin
      if (bt > v) begin
        bt = bt >> 2;
      end
    end
    for (int s = 0; s < 32; s++) begin
      if (bt != 64'd0) begin
        if (v >= r + bt) begin
          v = v - (r + bt);
          r = (r >> 1) + bt;
        end else begin
          r = r >> 1;
        end
        bt = bt >> 2;
      end
    end
    return r;
  endfunction

  // atan(2^-i) in radians Q48, from the truncated power series in Q60.
  function automatic logic [63:0] atan_q48(input int i);
    logic [63:0] v;
    logic [63:0] t;
    v = '0;
    if (i == 0) begin
      v = PI_Q60 >> 2;
    end else begin
      for (int k = 1; i * k <= 60; k += 2) begin
        t = div_u64(64'd1 << (60 - i * k), 64'(k));
        if ((k & 2) != 0) begin
          v = v - t;
        end else begin
          v = v + t;
        end
      end
    end
    return v >> 12;
  endfunction

  // Inverse CORDIC gain in Q30 for the given number of stages.
  function automatic logic [63:0] inv_gain_q30(input int stages);
    logic [63:0] p;
    p = 64'd1 << 60;
    for (int i = 0; i < stages; i++) begin
      if (2 * i < 64) begin
        p = p + (p >> (2 * i));
      end
    end
    return div_u64(64'd1 << 60, isqrt_u64(p));
  endfunction

endpackage

`default_nettype wire

// ===== rtl/paprot_mod_cell.sv =====
// One step of the modulo-360-degree reduction chain of the point rotator.
// Depends on paprot_pkg for the full-turn constant.
`default_nettype none

module paprot_mod_cell #(
  parameter int AW    = 42,
  parameter int SHIFT = 0
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          valid_i,
  input  wire logic          neg_i,
  input  wire logic [AW-1:0] rem_i,
  output logic               valid_o,
  output logic               neg_o,
  output logic [AW-1:0]      rem_o
);

  // Full turn scaled by this cell's power of two.
  localparam logic [AW-1:0] STEP = {{(AW - 25){1'b0}}, paprot_pkg::DEG360} << SHIFT;

  logic          valid_r;
  logic          neg_r;
  logic [AW-1:0] rem_r;
  logic [AW-1:0] rem_nxt;

  // Take one scaled full turn off when it fits.
  always_comb begin
    if (rem_i >= STEP) begin
      rem_nxt = rem_i - STEP;
    end else begin
      rem_nxt = rem_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    neg_r <= neg_i;
    rem_r <= rem_nxt;
  end

  assign valid_o = valid_r;
  assign neg_o   = neg_r;
  assign rem_o   = rem_r;

endmodule

`default_nettype wire

// ===== rtl/paprot_cordic_cell.sv =====
// One rotation-mode CORDIC micro-rotation of the point rotator.
// Depends on paprot_pkg for the vector struct and the arctangent table function.
`default_nettype none

module paprot_cordic_cell #(
  parameter int STAGE = 0
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire paprot_pkg::cordic_vec_t vec_i,
  output paprot_pkg::cordic_vec_t      vec_o
);

  localparam int XW = paprot_pkg::XW;
  localparam int ZW = paprot_pkg::ZW;
  localparam logic [63:0]          ATAN_FULL = paprot_pkg::atan_q48(STAGE);
  localparam logic signed [ZW-1:0] ATAN      = $signed(ATAN_FULL[ZW-1:0]);

  logic                    valid_r;
  paprot_pkg::cordic_vec_t vec_r;
  paprot_pkg::cordic_vec_t vec_nxt;
  logic signed [XW-1:0]    shx;
  logic signed [XW-1:0]    shy;

  // Rotate toward the residual angle; a non-negative residue turns counterclockwise.
  always_comb begin
    shx     = vec_i.y >>> STAGE;
    shy     = vec_i.x >>> STAGE;
    vec_nxt = vec_i;
    if (!vec_i.z[ZW-1]) begin
      vec_nxt.x = vec_i.x - shx;
      vec_nxt.y = vec_i.y + shy;
      vec_nxt.z = vec_i.z - ATAN;
    end else begin
      vec_nxt.x = vec_i.x + shx;
      vec_nxt.y = vec_i.y - shy;
      vec_nxt.z = vec_i.z + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= vec_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    vec_r <= vec_nxt;
  end

  always_comb begin
    vec_o       = vec_r;
    vec_o.valid = valid_r;
  end

endmodule

`default_nettype wire

// ===== rtl/polar_array_point_rotate.sv =====
// Top level of the polar array point rotator: angle pipeline, reduction chain,
// CORDIC chain and output saturation. Depends on paprot_pkg, paprot_mod_cell, paprot_cordic_cell.
`default_nettype none

// Rotates a Q16.16 point about the configured center by offset + delta * instance,
// reduced modulo 360 degrees. The block is a single pipeline: busy stays low and a
// new point is taken every cycle. Each result appears on out_item for one cycle with
// out_strobe high; its path holds the reduction chain (one cell per instance bit
// plus one) and the CORDIC chain (one cell per stage). The receiver cannot stall the
// block, so results must be taken as they come. Coordinates that leave the signed
// 32-bit range are clipped and flag saturated. The user must write configuration
// only while no point is in flight; the block itself does not enforce this.

module polar_array_point_rotate #(
  parameter int INSTANCE_BITS = 16,
  parameter int CORDIC_STAGES = 24
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire paprot_pkg::in_item_t in_item,
  output logic                      out_strobe,
  output paprot_pkg::out_item_t     out_item,
  input  wire logic                 cfg_we,
  input  wire logic [2:0]           cfg_index,
  input  wire logic [31:0]          cfg_wdata
);

  localparam int IB    = INSTANCE_BITS;
  localparam int PW    = 27 + IB;
  localparam int AW    = 26 + IB;
  localparam int NCELL = IB + 1;
  localparam int XDLY  = IB + 5;
  localparam int XW    = paprot_pkg::XW;
  localparam int ZW    = paprot_pkg::ZW;
  localparam int RW    = XW - 20;
  localparam logic [63:0]          INV_GAIN_FULL = paprot_pkg::inv_gain_q30(CORDIC_STAGES);
  localparam logic [29:0]          INV_GAIN      = INV_GAIN_FULL[29:0];
  localparam logic signed [XW-1:0] HALF_LSB      = XW'(524288);

  // Configuration registers.
  logic signed [31:0] center_x_r;
  logic signed [31:0] center_y_r;
  logic signed [25:0] delta_r;
  logic signed [25:0] offset_r;
  logic [1:0]         mode_r;

  logic accept;

  // Stage 1: angle product and point relative to the center.
  logic [IB+15:0]     inst_ext;
  logic [IB-1:0]      inst;
  logic signed [PW-1:0] prod1_nxt;
  logic signed [32:0] dx1_nxt;
  logic signed [32:0] dy1_nxt;
  logic               v1_r;
  logic signed [PW-1:0] prod1_r;
  logic signed [32:0] dx1_r;
  logic signed [32:0] dy1_r;

  // Stage 2: offset added, sign and magnitude; point scaled by the inverse gain.
  logic signed [25:0]   off;
  logic signed [PW-1:0] sum2;
  logic signed [PW-1:0] abs2;
  logic signed [63:0]   xp2;
  logic signed [63:0]   yp2;
  logic                 v2_r;
  logic                 neg2_r;
  logic [AW-1:0]        mag2_r;
  logic signed [XW-1:0] x2_r;
  logic signed [XW-1:0] y2_r;

  // Reduction chain taps.
  logic          mv [0:NCELL];
  logic          mn [0:NCELL];
  logic [AW-1:0] mr [0:NCELL];

  // Angle residue and quadrant stages.
  logic [24:0]             remf;
  logic [24:0]             a3_nxt;
  logic                    v3_r;
  logic [24:0]             a3_r;
  paprot_pkg::quad_t       q4_nxt;
  logic [24:0]             base4;
  logic signed [25:0]      rs4;
  logic [25:0]             rabs4;
  logic                    v4_r;
  paprot_pkg::quad_t       q4_r;
  logic                    rneg4_r;
  logic [21:0]             rmag4_r;
  logic                    v5_r;
  paprot_pkg::quad_t       q5_r;
  logic                    neg5_r;
  logic [56:0]             zp5_r;
  logic signed [ZW-1:0]    zm6;
  logic                    v6_r;
  paprot_pkg::quad_t       q6_r;
  logic signed [ZW-1:0]    z6_r;

  // Point delay line alongside the angle stages.
  logic signed [XW-1:0] xd_r [0:XDLY-1];
  logic signed [XW-1:0] yd_r [0:XDLY-1];

  // Rotator chain taps.
  paprot_pkg::cordic_vec_t cv [0:CORDIC_STAGES];
  paprot_pkg::cordic_vec_t cl;

  // Output stages.
  logic signed [XW-1:0] xq7;
  logic signed [XW-1:0] yq7;
  logic signed [XW-1:0] xh7;
  logic signed [XW-1:0] yh7;
  logic                 v7_r;
  logic signed [RW-1:0] xr7_r;
  logic signed [RW-1:0] yr7_r;
  logic signed [36:0]   sx8;
  logic signed [36:0]   sy8;
  logic                 ovx8;
  logic                 ovy8;
  paprot_pkg::out_item_t out_nxt;
  logic                 out_strobe_r;
  paprot_pkg::out_item_t out_item_r;

  // Every cycle can take a transaction.
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= '0;
      center_y_r <= '0;
      delta_r    <= '0;
      offset_r   <= '0;
      mode_r     <= paprot_pkg::MODE_NONE;
    end else if (cfg_we) begin
      case (cfg_index)
        paprot_pkg::CFG_CENTER_X:     center_x_r <= cfg_wdata;
        paprot_pkg::CFG_CENTER_Y:     center_y_r <= cfg_wdata;
        paprot_pkg::CFG_DELTA_ANGLE:  delta_r    <= cfg_wdata[25:0];
        paprot_pkg::CFG_OFFSET_ANGLE: offset_r   <= cfg_wdata[25:0];
        paprot_pkg::CFG_OFFSET_MODE:  mode_r     <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  // Stage 1 logic.
  assign inst_ext  = {{IB{1'b0}}, in_item.instance_req};
  assign inst      = inst_ext[IB-1:0];
  assign prod1_nxt = PW'(delta_r) * PW'($signed({1'b0, inst}));
  assign dx1_nxt   = 33'(in_item.point_x) - 33'(center_x_r);
  assign dy1_nxt   = 33'(in_item.point_y) - 33'(center_y_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    prod1_r <= prod1_nxt;
    dx1_r   <= dx1_nxt;
    dy1_r   <= dy1_nxt;
  end

  // Stage 2 logic: start angle selection and inverse gain scaling.
  always_comb begin
    case (mode_r)
      paprot_pkg::MODE_DELTA: off = delta_r;
      paprot_pkg::MODE_FREE:  off = offset_r;
      default:                off = '0;
    endcase
    sum2 = prod1_r + PW'(off);
    if (sum2[PW-1]) begin
      abs2 = -sum2;
    end else begin
      abs2 = sum2;
    end
    xp2 = 64'(dx1_r) * 64'($signed({1'b0, INV_GAIN}));
    yp2 = 64'(dy1_r) * 64'($signed({1'b0, INV_GAIN}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    neg2_r <= sum2[PW-1];
    mag2_r <= abs2[AW-1:0];
    x2_r   <= XW'(xp2 >>> 10);
    y2_r   <= XW'(yp2 >>> 10);
  end

  // Reduction chain: one cell per power of two of the full turn, largest first.
  assign mv[0] = v2_r;
  assign mn[0] = neg2_r;
  assign mr[0] = mag2_r;

  for (genvar j = 0; j < NCELL; j++) begin : g_mod
    paprot_mod_cell #(
      .AW    (AW),
      .SHIFT (IB - j)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (mv[j]),
      .neg_i   (mn[j]),
      .rem_i   (mr[j]),
      .valid_o (mv[j+1]),
      .neg_o   (mn[j+1]),
      .rem_o   (mr[j+1])
    );
  end

  // Negative sums fold back into the range zero to one full turn.
  assign remf = mr[NCELL][24:0];
  always_comb begin
    if (mn[NCELL] && remf != 25'd0) begin
      a3_nxt = paprot_pkg::DEG360 - remf;
    end else begin
      a3_nxt = remf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= mv[NCELL];
    end
  end

  always_ff @(posedge clk) begin
    a3_r <= a3_nxt;
  end

  // Split the angle into quarter turns and a residue within 45 degrees.
  always_comb begin
    if (a3_r < paprot_pkg::DEG45) begin
      q4_nxt = paprot_pkg::QUAD_0;
      base4  = '0;
    end else if (a3_r < paprot_pkg::DEG135) begin
      q4_nxt = paprot_pkg::QUAD_90;
      base4  = paprot_pkg::DEG90;
    end else if (a3_r < paprot_pkg::DEG225) begin
      q4_nxt = paprot_pkg::QUAD_180;
      base4  = paprot_pkg::DEG180;
    end else if (a3_r < paprot_pkg::DEG315) begin
      q4_nxt = paprot_pkg::QUAD_270;
      base4  = paprot_pkg::DEG270;
    end else begin
      q4_nxt = paprot_pkg::QUAD_0;
      base4  = paprot_pkg::DEG360;
    end
    rs4 = $signed({1'b0, a3_r}) - $signed({1'b0, base4});
    if (rs4[25]) begin
      rabs4 = -rs4;
    end else begin
      rabs4 = rs4;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    q4_r    <= q4_nxt;
    rneg4_r <= rs4[25];
    rmag4_r <= rabs4[21:0];
  end

  // Degrees to radians on the magnitude, so the truncation goes toward zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    q5_r   <= q4_r;
    neg5_r <= rneg4_r;
    zp5_r  <= 57'(rmag4_r) * 57'(paprot_pkg::RAD_C);
  end

  // Restore the sign of the residual angle.
  always_comb begin
    zm6 = $signed({1'b0, zp5_r[56:8]});
    if (neg5_r) begin
      zm6 = -zm6;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else begin
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    q6_r <= q5_r;
    z6_r <= zm6;
  end

  // Point delay line, matched to the angle stages.
  always_ff @(posedge clk) begin
    xd_r[0] <= x2_r;
    yd_r[0] <= y2_r;
    for (int k = 1; k < XDLY; k++) begin
      xd_r[k] <= xd_r[k-1];
      yd_r[k] <= yd_r[k-1];
    end
  end

  // Rotator chain.
  always_comb begin
    cv[0].valid = v6_r;
    cv[0].quad  = q6_r;
    cv[0].x     = xd_r[XDLY-1];
    cv[0].y     = yd_r[XDLY-1];
    cv[0].z     = z6_r;
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    paprot_cordic_cell #(
      .STAGE (i)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .vec_i (cv[i]),
      .vec_o (cv[i+1])
    );
  end

  assign cl = cv[CORDIC_STAGES];

  // Exact quarter turns, then rounding to Q16.16.
  always_comb begin
    case (cl.quad)
      paprot_pkg::QUAD_90: begin
        xq7 = -cl.y;
        yq7 = cl.x;
      end
      paprot_pkg::QUAD_180: begin
        xq7 = -cl.x;
        yq7 = -cl.y;
      end
      paprot_pkg::QUAD_270: begin
        xq7 = cl.y;
        yq7 = -cl.x;
      end
      default: begin
        xq7 = cl.x;
        yq7 = cl.y;
      end
    endcase
    xh7 = xq7 + HALF_LSB;
    yh7 = yq7 + HALF_LSB;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else begin
      v7_r <= cl.valid;
    end
  end

  always_ff @(posedge clk) begin
    xr7_r <= xh7[XW-1:20];
    yr7_r <= yh7[XW-1:20];
  end

  // Add the center back and clip each coordinate to the signed 32-bit range.
  always_comb begin
    sx8  = 37'(center_x_r) + 37'(xr7_r);
    sy8  = 37'(center_y_r) + 37'(yr7_r);
    ovx8 = (sx8[36:31] != {6{sx8[36]}});
    ovy8 = (sy8[36:31] != {6{sy8[36]}});
    if (ovx8) begin
      out_nxt.out_x = sx8[36] ? paprot_pkg::S32_MIN : paprot_pkg::S32_MAX;
    end else begin
      out_nxt.out_x = sx8[31:0];
    end
    if (ovy8) begin
      out_nxt.out_y = sy8[36] ? paprot_pkg::S32_MIN : paprot_pkg::S32_MAX;
    end else begin
      out_nxt.out_y = sy8[31:0];
    end
    out_nxt.saturated = ovx8 | ovy8;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  // The reduction chain leaves less than one full turn.
  a_rem_below_turn: assert property (@(posedge clk) disable iff (!rst_n)
    mv[NCELL] |-> (mr[NCELL] < AW'(paprot_pkg::DEG360)))
    else $error("reduction chain left a remainder of a full turn or more");

  // The residue stays within 45 degrees; exactly 45 only on the negative side.
  a_residue_range: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r |-> ((rmag4_r < 22'(paprot_pkg::DEG45)) ||
              (rmag4_r == 22'(paprot_pkg::DEG45) && rneg4_r)))
    else $error("angle residue outside the rotator range");

  // A strobe comes only from a vector that left the rotator and passed the rounding and output registers.
  a_strobe_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(cl.valid, 2))
    else $error("result strobe without a rotated vector behind it");

  // A saturated result carries a clipped coordinate.
  a_sat_clipped: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.saturated) |->
      (out_item.out_x == paprot_pkg::S32_MAX || out_item.out_x == paprot_pkg::S32_MIN ||
       out_item.out_y == paprot_pkg::S32_MAX || out_item.out_y == paprot_pkg::S32_MIN))
    else $error("saturated flag set on an unclipped result");

endmodule

`default_nettype wire
